// ===== hdl/teadec_pkg.sv =====
// shared types, constants and functions for the tea block decrypt pipeline
`default_nettype none

package teadec_pkg;

    localparam int unsigned WORD_W        = 32;
    localparam int unsigned DEF_ROUNDS    = 8;
    localparam int unsigned SHIFT_LEFT    = 4;
    localparam int unsigned SHIFT_RIGHT   = 5;
    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

    // configuration register indexes
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_0 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_1 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_2 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_3 = 3'd3;

    typedef struct packed {
        logic [WORD_W-1:0] low;
        logic [WORD_W-1:0] high;
    } t_word_pair;

    // round sum for a round with the given number of rounds still to go
    function automatic logic [WORD_W-1:0] round_sum(input int unsigned rounds_left);
        logic [63:0] prod;
        prod = 64'(TEA_DELTA) * 64'(rounds_left);
        return prod[WORD_W-1:0];
    endfunction

    // tea mix term of one half-round
    function automatic logic [WORD_W-1:0] mix_term(
        input logic [WORD_W-1:0] v,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
        left  = (v << SHIFT_LEFT) + ka;
        right = (v >> SHIFT_RIGHT) + kb;
        return left ^ (v + sum) ^ right;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/teadec_half_round.sv =====
// one registered tea decryption half-round stage
`default_nettype none

module teadec_half_round #(
    parameter bit                               P_UPDATE_HIGH = 1'b1,
    parameter logic [teadec_pkg::WORD_W-1:0]    P_SUM         = '0
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_en,
    input  wire                               i_valid,
    input  teadec_pkg::t_word_pair            i_data,
    input  wire  [teadec_pkg::WORD_W-1:0]     i_key_a,
    input  wire  [teadec_pkg::WORD_W-1:0]     i_key_b,
    output logic                              o_valid,
    output teadec_pkg::t_word_pair            o_data
);

    logic                   r_valid;
    teadec_pkg::t_word_pair r_data;
    teadec_pkg::t_word_pair n_data;

    always_comb begin
        n_data = i_data;
        if (P_UPDATE_HIGH) begin
            n_data.high = i_data.high
                - teadec_pkg::mix_term(i_data.low, P_SUM, i_key_a, i_key_b);
        end else begin
            n_data.low = i_data.low
                - teadec_pkg::mix_term(i_data.high, P_SUM, i_key_a, i_key_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== hdl/teadec_key_regs.sv =====
// key word configuration registers
`default_nettype none

module teadec_key_regs (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [teadec_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire  [teadec_pkg::WORD_W-1:0]       i_cfg_data,
    output logic [teadec_pkg::WORD_W-1:0]       o_key_0,
    output logic [teadec_pkg::WORD_W-1:0]       o_key_1,
    output logic [teadec_pkg::WORD_W-1:0]       o_key_2,
    output logic [teadec_pkg::WORD_W-1:0]       o_key_3
);

    logic [teadec_pkg::WORD_W-1:0] r_key_0;
    logic [teadec_pkg::WORD_W-1:0] r_key_1;
    logic [teadec_pkg::WORD_W-1:0] r_key_2;
    logic [teadec_pkg::WORD_W-1:0] r_key_3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_0 <= '0;
            r_key_1 <= '0;
            r_key_2 <= '0;
            r_key_3 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                teadec_pkg::CFG_KEY_0: r_key_0 <= i_cfg_data;
                teadec_pkg::CFG_KEY_1: r_key_1 <= i_cfg_data;
                teadec_pkg::CFG_KEY_2: r_key_2 <= i_cfg_data;
                teadec_pkg::CFG_KEY_3: r_key_3 <= i_cfg_data;
                default: ; // unknown index, write dropped
            endcase
        end
    end

    assign o_key_0 = r_key_0;
    assign o_key_1 = r_key_1;
    assign o_key_2 = r_key_2;
    assign o_key_3 = r_key_3;

    key0_write_lands : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_addr == teadec_pkg::CFG_KEY_0)
            |=> (r_key_0 == $past(i_cfg_data)))
        else $error("key word 0 write not taken");

endmodule

`default_nettype wire

// ===== hdl/tea_block_decrypt_8round.sv =====
// top level: pipelined tea block decryption, one half-round per stage
//
// input channel: i_valid / o_stall carry one request, a ciphertext pair
// (i_cipher_low, i_cipher_high); it is taken at a clock edge with i_valid high
// and o_stall low. output channel: o_valid / i_stall carry the plaintext pair
// (o_plain_low, o_plain_high), taken when o_valid is high and i_stall low.
// keys are written through i_cfg_we / i_cfg_addr / i_cfg_data, index 0..3
// for key words 0..3; other indexes are ignored. write keys only while idle.
// each of the ROUND_COUNT rounds (8 by default) is split into two registered
// half-rounds, the last stage doubling as the output register. throughput is
// one request per cycle while o_stall is low.
// when the receiver stalls, the held result stays put and earlier stages keep
// moving into empty slots; o_stall rises only once every stage holds a request.
// reset (synchronous, active low) empties the pipeline and clears the keys.
`default_nettype none

module tea_block_decrypt_8round #(
    parameter int unsigned ROUND_COUNT = teadec_pkg::DEF_ROUNDS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // ciphertext requests
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire  [teadec_pkg::WORD_W-1:0]       i_cipher_low,
    input  wire  [teadec_pkg::WORD_W-1:0]       i_cipher_high,
    // plaintext results
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic [teadec_pkg::WORD_W-1:0]       o_plain_low,
    output logic [teadec_pkg::WORD_W-1:0]       o_plain_high,
    // key configuration
    input  wire                                 i_cfg_we,
    input  wire  [teadec_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire  [teadec_pkg::WORD_W-1:0]       i_cfg_data
);

    localparam int unsigned STAGE_COUNT = 2 * ROUND_COUNT;

    logic [teadec_pkg::WORD_W-1:0] w_key_0;
    logic [teadec_pkg::WORD_W-1:0] w_key_1;
    logic [teadec_pkg::WORD_W-1:0] w_key_2;
    logic [teadec_pkg::WORD_W-1:0] w_key_3;

    // index k is the input of stage k; index STAGE_COUNT is the output
    teadec_pkg::t_word_pair        w_data  [0:STAGE_COUNT];
    logic [STAGE_COUNT:0]          w_valid;
    logic [STAGE_COUNT-1:0]        w_en;

    teadec_key_regs u_keys (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_key_0    (w_key_0),
        .o_key_1    (w_key_1),
        .o_key_2    (w_key_2),
        .o_key_3    (w_key_3)
    );

    assign w_valid[0]     = i_valid;
    assign w_data[0].low  = i_cipher_low;
    assign w_data[0].high = i_cipher_high;

    // last stage moves when empty or when the receiver takes its result
    assign w_en[STAGE_COUNT-1] = !w_valid[STAGE_COUNT] || !i_stall;

    genvar k;
    generate
        for (k = 0; k < STAGE_COUNT; k++) begin : g_stage
            // even stage updates high with k2/k3, odd stage updates low with k0/k1
            localparam bit UPDATE_HIGH = ((k % 2) == 0);
            localparam logic [teadec_pkg::WORD_W-1:0] STAGE_SUM =
                teadec_pkg::round_sum(ROUND_COUNT - (k / 2));

            if (k < STAGE_COUNT - 1) begin : g_en
                // bubble collapse: a stage loads when its slot is free or drains
                assign w_en[k] = !w_valid[k+1] || w_en[k+1];
            end

            teadec_half_round #(
                .P_UPDATE_HIGH (UPDATE_HIGH),
                .P_SUM         (STAGE_SUM)
            ) u_half (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en[k]),
                .i_valid (w_valid[k]),
                .i_data  (w_data[k]),
                .i_key_a (UPDATE_HIGH ? w_key_2 : w_key_0),
                .i_key_b (UPDATE_HIGH ? w_key_3 : w_key_1),
                .o_valid (w_valid[k+1]),
                .o_data  (w_data[k+1])
            );
        end
    endgenerate

    assign o_stall      = !w_en[0];
    assign o_valid      = w_valid[STAGE_COUNT];
    assign o_plain_low  = w_data[STAGE_COUNT].low;
    assign o_plain_high = w_data[STAGE_COUNT].high;

    // input is held back only when every stage is occupied
    stall_only_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&w_valid[STAGE_COUNT:1]))
        else $error("input stalled with an empty stage");

    // input is never held back while the receiver takes results
    stall_only_from_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> i_stall)
        else $error("input stalled without output stall");

    // reset empties the pipeline
    reset_empties : assert property (@(posedge i_clk)
        !i_rst_n |=> (w_valid[STAGE_COUNT:1] == '0))
        else $error("pipeline not empty after reset");

    // a result waiting at a stalled output is not dropped
    held_result_kept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("stalled result lost");

endmodule

`default_nettype wire
